// ===== rtl/bpsk_mod_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsk_mod_pkg
// Shared constants, tables and types of the BPSK root-raised-cosine modulator.
// ----------------------------------------------------------------------------
package bpsk_mod_pkg;

	localparam int SAMPLES_PER_SYMBOL_DEF = 20;
	localparam int FILTER_TAPS_DEF        = 101;
	localparam int ROM_TAPS               = 101;
	localparam int COS_TABLE_DEPTH        = 1024;
	localparam int COS_ADDR_W             = $clog2(COS_TABLE_DEPTH);
	localparam int SLOT_W                 = 5;
	localparam int TAP_IDX_W              = 9;
	localparam int CFG_IDX_W              = 4;
	localparam int CFG_DATA_W             = 32;
	localparam int PHASE_W                = 32;
	localparam int COEF_W                 = 16;
	localparam int DAC_W                  = 12;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned ONE_Q30     = 64'd1 << 30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_STEP  = 4'd0,
		REG_START_PHASE = 4'd1
	} cfg_reg_t;

	typedef struct packed {
		logic              shift;
		logic              sym_bit;
		logic              issue;
		logic              last;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic can_advance;
	} status_t;

	typedef logic signed [COEF_W-1:0] cos_rom_t [COS_TABLE_DEPTH];

	localparam logic signed [COEF_W-1:0] RRC_HALF [51] = '{
		16'sd952, 16'sd960, 16'sd943, 16'sd903, 16'sd837, 16'sd748, 16'sd636,
		16'sd503, 16'sd350, 16'sd182, 16'sd0, -16'sd191, -16'sd387, -16'sd584,
		-16'sd777, -16'sd962, -16'sd1133, -16'sd1285, -16'sd1415, -16'sd1517,
		-16'sd1587, -16'sd1621, -16'sd1620, -16'sd1571, -16'sd1481, -16'sd1347,
		-16'sd1166, -16'sd940, -16'sd669, -16'sd355, 16'sd0, 16'sd392, 16'sd817,
		16'sd1271, 16'sd1749, 16'sd2244, 16'sd2751, 16'sd3263, 16'sd3773,
		16'sd4275, 16'sd4761, 16'sd5225, 16'sd5660, 16'sd6060, 16'sd6419,
		16'sd6733, 16'sd6996, 16'sd7205, 16'sd7356, 16'sd7448, 16'sd7478
	};

	function automatic logic signed [COEF_W-1:0] rrc_tap(logic [TAP_IDX_W-1:0] i,
			int taps);
		logic [TAP_IDX_W-1:0] m;
		m = (i <= TAP_IDX_W'(50)) ? i : TAP_IDX_W'(100) - i;
		if ((int'(i) >= taps) || (int'(i) >= ROM_TAPS))
			return '0;
		return RRC_HALF[m[5:0]];
	endfunction

	function automatic longint unsigned taylor_div(longint unsigned x, int k, bit odd);
		case (k)
			1: return odd ? x / 64'd6 : x / 64'd2;
			2: return odd ? x / 64'd20 : x / 64'd12;
			3: return odd ? x / 64'd42 : x / 64'd30;
			4: return odd ? x / 64'd72 : x / 64'd56;
			5: return odd ? x / 64'd110 : x / 64'd90;
			6: return odd ? x / 64'd156 : x / 64'd132;
			7: return odd ? x / 64'd210 : x / 64'd182;
			8: return odd ? x / 64'd272 : x / 64'd240;
			default: return odd ? x / 64'd342 : x / 64'd306;
		endcase
	endfunction

	function automatic longint taylor_q30(longint unsigned theta, bit odd);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2   = (theta * theta) >> 30;
		term = odd ? theta : ONE_Q30;
		sum  = longint'(term);
		for (int k = 1; k <= 9; k++) begin
			term = taylor_div((term * x2) >> 30, k, odd);
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return sum;
	endfunction

	function automatic logic signed [COEF_W-1:0] q30_to_q15(longint v);
		longint unsigned r;
		if (v < 0)
			v = 0;
		r = (longint'(v) + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return COEF_W'(r);
	endfunction

	function automatic cos_rom_t build_cos_rom();
		cos_rom_t               rom;
		longint unsigned        q;
		longint unsigned        rem;
		longint unsigned        theta;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] s;
		for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
			q     = longint'(4 * i) / COS_TABLE_DEPTH;
			rem   = longint'(4 * i) - q * COS_TABLE_DEPTH;
			theta = (rem * HALF_PI_Q30) / COS_TABLE_DEPTH;
			c     = q30_to_q15(taylor_q30(theta, 1'b0));
			s     = q30_to_q15(taylor_q30(theta, 1'b1));
			case (q[1:0])
				2'd0: rom[i] = c;
				2'd1: rom[i] = -s;
				2'd2: rom[i] = -c;
				default: rom[i] = s;
			endcase
		end
		return rom;
	endfunction

endpackage

// ===== rtl/bpsk_mod_if.sv =====
// ----------------------------------------------------------------------------
// bpsk_mod_if
// Valid/ready channels of the modulator: input bits, DAC samples, register writes.
// ----------------------------------------------------------------------------
interface bpsk_mod_bit_if;
	logic valid;
	logic ready;
	logic data_bit;

	modport source (output valid, output data_bit, input ready);
	modport sink (input valid, input data_bit, output ready);
endinterface

interface bpsk_mod_dac_if;
	logic        valid;
	logic        ready;
	logic [11:0] dac_sample;
	logic        last_of_symbol;

	modport source (output valid, output dac_sample, output last_of_symbol, input ready);
	modport sink (input valid, input dac_sample, input last_of_symbol, output ready);
endinterface

interface bpsk_mod_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bpsk_mod_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpsk_mod_ctrl
// Symbol sequencer: takes a bit request and issues one sample slot per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module bpsk_mod_ctrl #(
	parameter int SAMPLES_PER_SYMBOL = bpsk_mod_pkg::SAMPLES_PER_SYMBOL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bpsk_mod_bit_if.sink          bits,
	input  bpsk_mod_pkg::status_t status,
	output bpsk_mod_pkg::cmd_t    cmd
);
	import bpsk_mod_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] slot_q;
	logic              issue;
	logic              last;
	logic              accept;

	assign issue      = (state_q == ST_RUN) && status.can_advance;
	assign last       = (slot_q == SLOT_W'(SAMPLES_PER_SYMBOL - 1));
	assign bits.ready = (state_q == ST_IDLE) || (issue && last);
	assign accept     = bits.valid && bits.ready;

	assign cmd.shift   = accept;
	assign cmd.sym_bit = bits.data_bit;
	assign cmd.issue   = issue;
	assign cmd.last    = last;
	assign cmd.slot    = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						slot_q  <= '0;
					end
				end
				ST_RUN: begin
					if (accept) begin
						slot_q <= '0;
					end else if (issue && last) begin
						state_q <= ST_IDLE;
						slot_q  <= '0;
					end else if (issue) begin
						slot_q <= slot_q + SLOT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
					slot_q  <= '0;
				end
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (slot_q == '0))
		else $error("bit request did not start a symbol at slot zero");

	a_stall_holds_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && !status.can_advance |=> $stable(slot_q))
		else $error("sample slot moved during output stall");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(SAMPLES_PER_SYMBOL - 1))
		else $error("sample slot beyond symbol length");

endmodule

// ===== rtl/bpsk_mod_dp.sv =====
// ----------------------------------------------------------------------------
// bpsk_mod_dp
// Polyphase RRC sum, cosine ROM, mixer multiply, offset and saturate, output reg.
// ----------------------------------------------------------------------------
module bpsk_mod_dp #(
	parameter int SAMPLES_PER_SYMBOL = bpsk_mod_pkg::SAMPLES_PER_SYMBOL_DEF,
	parameter int FILTER_TAPS        = bpsk_mod_pkg::FILTER_TAPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bpsk_mod_pkg::cmd_t     cmd,
	output bpsk_mod_pkg::status_t  status,
	bpsk_mod_cfg_if.sink           cfg,
	bpsk_mod_dac_if.source         samples
);
	import bpsk_mod_pkg::*;

	localparam int HIST_DEPTH = (FILTER_TAPS + SAMPLES_PER_SYMBOL - 1) / SAMPLES_PER_SYMBOL;
	localparam int ACC_W      = COEF_W + 1 + $clog2(HIST_DEPTH);
	localparam int PROD_W     = ACC_W + COEF_W;
	localparam int T_W        = ((PROD_W > 31) ? PROD_W : 31) + 1;
	localparam int V_W        = T_W - 19;
	localparam logic signed [T_W-1:0] ROUND_OFFSET = (T_W'(2048) << 19) + (T_W'(1) << 18);
	localparam cos_rom_t COS_ROM = build_cos_rom();

	logic                     hist_q [HIST_DEPTH];
	logic [PHASE_W-1:0]       phase_q;
	logic [PHASE_W-1:0]       step_q;
	logic                     advance;
	logic                     cfg_wr;
	logic signed [ACC_W-1:0]  acc;
	logic signed [COEF_W-1:0] tap;
	logic [TAP_IDX_W-1:0]     tap_idx;

	logic                     v_s1;
	logic                     last_s1;
	logic signed [ACC_W-1:0]  acc_s1;
	logic signed [COEF_W-1:0] cos_s1;
	logic                     v_s2;
	logic                     last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [T_W-1:0]    t_sum;
	logic [V_W-1:0]           t_shift;
	logic [DAC_W-1:0]         dac_sat;

	logic                     out_valid_q;
	logic [DAC_W-1:0]         dac_q;
	logic                     last_q;

	assign advance            = !out_valid_q || samples.ready;
	assign status.can_advance = advance;
	assign cfg.ready          = 1'b1;
	assign cfg_wr             = cfg.valid && cfg.ready;

	assign samples.valid          = out_valid_q;
	assign samples.dac_sample     = dac_q;
	assign samples.last_of_symbol = last_q;

	always_comb begin
		acc     = '0;
		tap     = '0;
		tap_idx = '0;
		for (int d = 0; d < HIST_DEPTH; d++) begin
			tap_idx = TAP_IDX_W'(cmd.slot) + TAP_IDX_W'(d * SAMPLES_PER_SYMBOL);
			tap     = rrc_tap(tap_idx, FILTER_TAPS);
			if (hist_q[d])
				acc = acc + ACC_W'(tap);
			else
				acc = acc - ACC_W'(tap);
		end
	end

	always_comb begin
		t_sum   = T_W'(prod_s2) + ROUND_OFFSET;
		t_shift = t_sum[T_W-1:19];
		if (t_sum[T_W-1])
			dac_sat = '0;
		else if (t_shift > V_W'(4095))
			dac_sat = DAC_W'(4095);
		else
			dac_sat = t_shift[DAC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < HIST_DEPTH; d++)
				hist_q[d] <= 1'b0;
			phase_q <= '0;
			step_q  <= '0;
		end else begin
			if (cmd.shift) begin
				hist_q[0] <= cmd.sym_bit;
				for (int d = 1; d < HIST_DEPTH; d++)
					hist_q[d] <= hist_q[d-1];
			end
			if (cfg_wr && (cfg.index == REG_PHASE_STEP))
				step_q <= cfg.data;
			if (cfg_wr && (cfg.index == REG_START_PHASE))
				phase_q <= cfg.data;
			else if (cmd.issue)
				phase_q <= phase_q + step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cos_s1  <= COS_ROM[phase_q[PHASE_W-1 -: COS_ADDR_W]];
			acc_s1  <= acc;
			last_s1 <= cmd.last;
			prod_s2 <= PROD_W'(acc_s1) * PROD_W'(cos_s1);
			last_s2 <= last_s1;
			dac_q   <= dac_sat;
			last_q  <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue && !cfg_wr |=> phase_q == $past(phase_q + step_q))
		else $error("carrier phase did not advance by one step per sample");

	a_pipe_moves: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && advance |=> out_valid_q)
		else $error("sample lost between multiply and output stage");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !samples.ready |=> out_valid_q && $stable(dac_q) && $stable(last_q))
		else $error("sample changed while output stalled");

endmodule

// ===== rtl/bpsk_rrc_upconvert_modulator_top.sv =====
// ----------------------------------------------------------------------------
// bpsk_rrc_upconvert_modulator_top
// BPSK modulator with RRC pulse shaping and cosine up-conversion to a 12-bit DAC.
// ----------------------------------------------------------------------------
// A taken bit request starts the sample-slot sequencer; each sample then passes the
// stage-1, stage-2 and output registers. The sequencer issues SAMPLES_PER_SYMBOL samples
// per bit, one sample per cycle; a stalled output holds the whole sample pipeline.
// Reset clears history (symbol -1), carrier phase, phase step and the pipeline valid flags.
// The cosine ROM is constant and needs no fill after reset.
// ----------------------------------------------------------------------------
module bpsk_rrc_upconvert_modulator_top #(
	parameter int SAMPLES_PER_SYMBOL = bpsk_mod_pkg::SAMPLES_PER_SYMBOL_DEF,
	parameter int FILTER_TAPS        = bpsk_mod_pkg::FILTER_TAPS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	bpsk_mod_bit_if.sink     bits,
	bpsk_mod_dac_if.source   samples,
	bpsk_mod_cfg_if.sink     cfg
);
	import bpsk_mod_pkg::*;

	cmd_t    cmd;
	status_t status;

	bpsk_mod_ctrl #(
		.SAMPLES_PER_SYMBOL(SAMPLES_PER_SYMBOL)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.bits  (bits),
		.status(status),
		.cmd   (cmd)
	);

	bpsk_mod_dp #(
		.SAMPLES_PER_SYMBOL(SAMPLES_PER_SYMBOL),
		.FILTER_TAPS       (FILTER_TAPS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.cfg    (cfg),
		.samples(samples)
	);

endmodule

// ===== dv/bpsk_rrc_upconvert_modulator_top_test.sv =====
// ----------------------------------------------------------------------------
// bpsk_rrc_upconvert_modulator_top_test
// Drives data bits through the BPSK modulator and checks every DAC sample and
// its end-of-symbol flag. The expected samples come from a local model of the
// shaping filter, the carrier table and the phase accumulator. A short plan of
// fixed requests runs first: reset state, quarter-turn carriers that give mid
// scale, ignored register writes, extreme phase steps. Random phases with random
// carrier settings follow, all but one with random stalls on both channels.
// ----------------------------------------------------------------------------
module bpsk_rrc_upconvert_modulator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SYMBOL_SAMPLES = 20;
	localparam int TAP_COUNT      = 101;
	localparam int HISTORY        = 6;
	localparam int COS_DEPTH      = 1024;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_PHASES  = 8;
	localparam int BITS_PER_PHASE = 40;
	localparam int IDLE_PERCENT   = 13;

	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
	localparam longint unsigned UNITY_Q30        = 64'd1 << 30;

	localparam logic [bpsk_mod_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
	localparam logic [bpsk_mod_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
	localparam logic [bpsk_mod_pkg::DAC_W-1:0]     MID_LEVEL     = 12'd2048;
	localparam logic [bpsk_mod_pkg::DAC_W-1:0]     TOP_LEVEL     = 12'd4095;

	localparam int RRC_PROFILE [51] = '{
		952, 960, 943, 903, 837, 748, 636, 503, 350, 182,
		0, -191, -387, -584, -777, -962, -1133, -1285, -1415, -1517,
		-1587, -1621, -1620, -1571, -1481, -1347, -1166, -940, -669, -355,
		0, 392, 817, 1271, 1749, 2244, 2751, 3263, 3773, 4275,
		4761, 5225, 5660, 6060, 6419, 6733, 6996, 7205, 7356, 7448,
		7478
	};

	typedef enum logic {ROW_BIT, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t                          kind;
		logic [bpsk_mod_pkg::CFG_IDX_W-1:0] index;
		logic [31:0]                        value;
		logic                               bit_in;
		logic                               pinned;
		logic [bpsk_mod_pkg::DAC_W-1:0]     pinned_level;
	} stim_row_t;

	typedef struct packed {
		logic [bpsk_mod_pkg::DAC_W-1:0] dac;
		logic                           last;
	} dac_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic steady = 1'b0;
	int   mismatches = 0;
	int   cycles = 0;

	bpsk_mod_bit_if bit_ch ();
	bpsk_mod_dac_if dac_ch ();
	bpsk_mod_cfg_if cfg_ch ();

	bpsk_rrc_upconvert_modulator_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bits    (bit_ch),
		.samples (dac_ch),
		.cfg     (cfg_ch)
	);

	// carrier and filter state mirrored from the design
	int                cos_table [COS_DEPTH];
	logic [31:0]       step_reg;
	logic [31:0]       carrier_acc;
	logic [HISTORY-1:0] recent_bits;
	dac_word_t         expected_samples [$];

	stim_row_t plan [26] = '{
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_REG, bpsk_mod_pkg::REG_START_PHASE, 32'h4000_0000, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b1, MID_LEVEL},
		'{ROW_REG, bpsk_mod_pkg::REG_START_PHASE, 32'hC000_0000, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b1, MID_LEVEL},
		'{ROW_REG, REG_UNUSED_LO, 32'hFFFF_FFFF, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_REG, REG_UNUSED_HI, 32'h0000_0001, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b1, MID_LEVEL},
		'{ROW_REG, bpsk_mod_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_REG, bpsk_mod_pkg::REG_START_PHASE, 32'h0000_0000, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_REG, bpsk_mod_pkg::REG_PHASE_STEP, 32'h8000_0000, 1'b0, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b1, 1'b0, MID_LEVEL},
		'{ROW_BIT, bpsk_mod_pkg::REG_PHASE_STEP, 32'h0, 1'b0, 1'b0, MID_LEVEL}
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint series_q30(longint unsigned angle, bit sine);
		longint unsigned sq;
		longint unsigned term;
		longint unsigned divisor;
		longint          acc;
		sq   = (angle * angle) >> 30;
		term = sine ? angle : UNITY_Q30;
		acc  = longint'(term);
		for (int k = 1; k <= 9; k++) begin
			divisor = sine ? longint'((2 * k) * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
			term    = ((term * sq) >> 30) / divisor;
			acc     = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
		end
		return acc;
	endfunction

	function automatic int to_q15(longint v);
		longint r;
		if (v < 0)
			return 0;
		r = (v + 64'sd16384) >>> 15;
		return (r > 32767) ? 32767 : int'(r);
	endfunction

	task automatic build_carrier_table();
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned angle;
		int              c;
		int              s;
		for (int i = 0; i < COS_DEPTH; i++) begin
			quad  = longint'(4 * i) / COS_DEPTH;
			rem   = longint'(4 * i) - quad * COS_DEPTH;
			angle = (rem * QUARTER_TURN_Q30) / COS_DEPTH;
			c     = to_q15(series_q30(angle, 1'b0));
			s     = to_q15(series_q30(angle, 1'b1));
			case (quad)
				0: begin
					cos_table[i] = c;
				end
				1: begin
					cos_table[i] = -s;
				end
				2: begin
					cos_table[i] = -c;
				end
				default: begin
					cos_table[i] = s;
				end
			endcase
		end
	endtask

	function automatic int tap_at(int i);
		if (i >= TAP_COUNT)
			return 0;
		return RRC_PROFILE[(i <= 50) ? i : 100 - i];
	endfunction

	// shape one symbol, mix it onto the carrier and queue its samples
	task automatic shape_and_mix(input logic b, input logic pinned,
			input logic [bpsk_mod_pkg::DAC_W-1:0] pinned_level);
		int        sum;
		longint    mixed;
		dac_word_t w;
		recent_bits = {recent_bits[HISTORY-2:0], b};
		for (int slot = 0; slot < SYMBOL_SAMPLES; slot++) begin
			sum = 0;
			for (int d = 0; d < HISTORY; d++)
				sum += recent_bits[d] ? tap_at(slot + d * SYMBOL_SAMPLES)
					: -tap_at(slot + d * SYMBOL_SAMPLES);
			mixed = longint'(sum) * longint'(cos_table[carrier_acc[31:22]])
				+ (64'sd2048 <<< 19) + (64'sd1 <<< 18);
			if (mixed < 0)
				w.dac = '0;
			else if ((mixed >>> 19) > 4095)
				w.dac = TOP_LEVEL;
			else
				w.dac = 12'(mixed >>> 19);
			if (pinned)
				w.dac = pinned_level;
			w.last = (slot == SYMBOL_SAMPLES - 1);
			expected_samples.push_back(w);
			carrier_acc += step_reg;
		end
	endtask

	task automatic note_reg_write(input logic [bpsk_mod_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		case (idx)
			bpsk_mod_pkg::REG_PHASE_STEP: begin
				step_reg = value;
			end
			bpsk_mod_pkg::REG_START_PHASE: begin
				carrier_acc = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		bit_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bpsk_mod_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] value);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		note_reg_write(idx, value);
	endtask

	task automatic send_bit(input logic b, input logic pinned,
			input logic [bpsk_mod_pkg::DAC_W-1:0] pinned_level);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			bit_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bit_ch.valid    <= 1'b1;
		bit_ch.data_bit <= b;
		do @(posedge clk); while (!bit_ch.ready);
		shape_and_mix(b, pinned, pinned_level);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return {8'($urandom_range(0, 255)), 24'h0};
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin : sample_check
		dac_word_t want;
		if (arst_n) begin
			if (dac_ch.valid && dac_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$error("dac_sample: none expected, got %0d", dac_ch.dac_sample);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					if (dac_ch.dac_sample !== want.dac) begin
						$error("dac_sample: expected %0d, got %0d", want.dac,
							dac_ch.dac_sample);
						mismatches++;
					end
					if (dac_ch.last_of_symbol !== want.last) begin
						$error("last_of_symbol: expected %0b, got %0b", want.last,
							dac_ch.last_of_symbol);
						mismatches++;
					end
				end
			end
			dac_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end else begin
			dac_ch.ready <= 1'b0;
		end
	end

	initial begin
		bit_ch.valid    <= 1'b0;
		bit_ch.data_bit <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= bpsk_mod_pkg::REG_PHASE_STEP;
		cfg_ch.data     <= '0;
		step_reg    = '0;
		carrier_acc = '0;
		recent_bits = '0;
		build_carrier_table();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_REG)
				write_reg(plan[r].index, plan[r].value);
			else
				send_bit(plan[r].bit_in, plan[r].pinned, plan[r].pinned_level);
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_reg(bpsk_mod_pkg::REG_PHASE_STEP, pick_word());
			write_reg(bpsk_mod_pkg::REG_START_PHASE, pick_word());
			if ($urandom_range(0, 2) == 0)
				write_reg(4'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), $urandom);
			steady = (p == RANDOM_PHASES / 2);
			for (int n = 0; n < BITS_PER_PHASE; n++)
				send_bit(1'($urandom_range(0, 1)), 1'b0, MID_LEVEL);
		end
		steady = 1'b0;

		wait_idle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
